FILE: hw/rtl/cgc_pkg.sv
package cgc_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int FIELD_BITS     = 16;
	localparam int IDX_BITS       = 3;

	typedef enum logic [IDX_BITS-1:0] {
		REG_IMAGE_W  = 3'd0,
		REG_IMAGE_H  = 3'd1,
		REG_TILE_W   = 3'd2,
		REG_TILE_H   = 3'd3,
		REG_DECOMP   = 3'd4,
		REG_BEXP_W   = 3'd5,
		REG_BEXP_H   = 3'd6,
		REG_UNUSED   = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		ORI_LL = 2'd0,
		ORI_HL = 2'd1,
		ORI_LH = 2'd2,
		ORI_HH = 2'd3
	} orient_t;

	typedef struct packed {
		logic [15:0] image_w;
		logic [15:0] image_h;
		logic [15:0] tile_w_set;
		logic [15:0] tile_h_set;
		logic [3:0]  decomp;
		logic [2:0]  bexp_w;
		logic [2:0]  bexp_h;
	} cfg_t;

	typedef struct packed {
		logic [15:0] tile_index;
		logic [3:0]  res_level;
		logic [1:0]  band_index;
		logic [19:0] block_index;
	} query_t;

	typedef struct packed {
		logic        ok;
		orient_t     orient;
		logic [15:0] band_x0;
		logic [15:0] band_y0;
		logic [15:0] band_w;
		logic [15:0] band_h;
		logic [14:0] nbx;
		logic [14:0] nby;
	} band_t;

	function automatic logic [15:0] nominal_size(input logic [15:0] setting,
		input logic [15:0] full);
		if (setting == 16'd0 || setting > full)
			return full;
		return setting;
	endfunction

	function automatic logic [2:0] clamp_exp(input logic [2:0] e);
		if (e < 3'd2)
			return 3'd2;
		if (e > 3'd6)
			return 3'd6;
		return e;
	endfunction

endpackage

FILE: hw/rtl/codeblock_geometry_calculator_unit.sv
// Code-block geometry: tile, band and code-block rectangle for one query.
// Pipeline: 17 + 16 + 4 + 20 divider and band stages and one output register;
// one restoring quotient bit per stage.
// Throughput: one query per cycle; a stalled output holds the whole pipeline.
// Reset clears configuration to its defaults and all valid bits.
module codeblock_geometry_calculator_unit import cgc_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [IDX_BITS-1:0] cfg_index,
	input  logic [15:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [15:0]         tile_index,
	input  logic [3:0]          res_level,
	input  logic [1:0]          band_index,
	input  logic [19:0]         block_index,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                valid_res,
	output logic [1:0]          orientation,
	output logic [15:0]         band_x0,
	output logic [15:0]         band_y0,
	output logic [15:0]         band_w,
	output logic [15:0]         band_h,
	output logic [14:0]         blocks_across,
	output logic [14:0]         blocks_down,
	output logic [15:0]         blk_x0,
	output logic [15:0]         blk_y0,
	output logic [15:0]         blk_x1,
	output logic [15:0]         blk_y1
);

	localparam int KEEP = (COORD_BITS < FIELD_BITS) ? COORD_BITS : FIELD_BITS;
	localparam logic [FIELD_BITS-1:0] CMASK = FIELD_BITS'((33'd1 << KEEP) - 33'd1);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_w    <= 16'd1;
			cfg_q.image_h    <= 16'd1;
			cfg_q.tile_w_set <= 16'd0;
			cfg_q.tile_h_set <= 16'd0;
			cfg_q.decomp     <= 4'd5;
			cfg_q.bexp_w     <= 3'd6;
			cfg_q.bexp_h     <= 3'd6;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_IMAGE_W: cfg_q.image_w    <= cfg_data;
				REG_IMAGE_H: cfg_q.image_h    <= cfg_data;
				REG_TILE_W:  cfg_q.tile_w_set <= cfg_data;
				REG_TILE_H:  cfg_q.tile_h_set <= cfg_data;
				REG_DECOMP:  cfg_q.decomp     <= cfg_data[3:0];
				REG_BEXP_W:  cfg_q.bexp_w     <= cfg_data[2:0];
				REG_BEXP_H:  cfg_q.bexp_h     <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	logic [15:0] tw;
	logic [2:0]  ew, eh;
	assign tw = nominal_size(cfg_q.tile_w_set, cfg_q.image_w);
	assign ew = clamp_exp(cfg_q.bexp_w);
	assign eh = clamp_exp(cfg_q.bexp_h);

	query_t qry_in;
	assign qry_in = '{tile_index: tile_index, res_level: res_level,
		band_index: band_index, block_index: block_index};

	// tiles across = ceil(image width / tile width)
	logic        nx_vld;
	logic [16:0] nx_quo;
	logic [15:0] nx_rem;
	query_t      nx_qry;

	cgc_div_pipe #(.NB(17), .DB(16), .PW($bits(query_t))) u_nx_div (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_vld(in_valid),
		.in_dvd(17'(cfg_q.image_w) + 17'(tw) - 17'd1),
		.in_dsr(tw),
		.in_pay(qry_in),
		.out_vld(nx_vld), .out_quo(nx_quo), .out_rem(nx_rem), .out_pay(nx_qry)
	);

	// tile row and column
	logic        td_vld;
	logic [15:0] td_quo;
	logic [16:0] td_rem;
	query_t      td_qry;

	cgc_div_pipe #(.NB(16), .DB(17), .PW($bits(query_t))) u_tile_div (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_vld(nx_vld),
		.in_dvd(nx_qry.tile_index),
		.in_dsr(nx_quo),
		.in_pay(nx_qry),
		.out_vld(td_vld), .out_quo(td_quo), .out_rem(td_rem), .out_pay(td_qry)
	);

	logic        bc_vld;
	band_t       bc_band;
	logic [19:0] bc_bi;

	cgc_band_calc u_band (
		.clk(clk), .arst_n(arst_n), .en(en), .cfg(cfg_q),
		.in_vld(td_vld), .tile_q(td_quo), .tile_p(td_rem), .in_qry(td_qry),
		.out_vld(bc_vld), .out_band(bc_band), .out_bi(bc_bi)
	);

	// code-block row and column
	logic        bd_vld;
	logic [19:0] bd_quo;
	logic [14:0] bd_rem;
	band_t       bd_band;

	cgc_div_pipe #(.NB(20), .DB(15), .PW($bits(band_t))) u_blk_div (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_vld(bc_vld),
		.in_dvd(bc_bi),
		.in_dsr(bc_band.nbx),
		.in_pay(bc_band),
		.out_vld(bd_vld), .out_quo(bd_quo), .out_rem(bd_rem), .out_pay(bd_band)
	);

	logic        blk_ok;
	logic [21:0] bx0, by0, bx1, by1;

	always_comb begin
		blk_ok = bd_band.ok && (bd_band.nbx != 15'd0) && (bd_quo < 20'(bd_band.nby));
		bx0 = 22'(bd_rem) << ew;
		by0 = 22'(bd_quo) << eh;
		bx1 = bx0 + (22'd1 << ew);
		by1 = by0 + (22'd1 << eh);
		if (bx1 > 22'(bd_band.band_w))
			bx1 = 22'(bd_band.band_w);
		if (by1 > 22'(bd_band.band_h))
			by1 = 22'(bd_band.band_h);
	end

	logic valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (en)
			valid_q <= bd_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			valid_res     <= blk_ok;
			orientation   <= bd_band.ok ? bd_band.orient : ORI_LL;
			band_x0       <= bd_band.ok ? (bd_band.band_x0 & CMASK) : 16'd0;
			band_y0       <= bd_band.ok ? (bd_band.band_y0 & CMASK) : 16'd0;
			band_w        <= bd_band.ok ? (bd_band.band_w & CMASK) : 16'd0;
			band_h        <= bd_band.ok ? (bd_band.band_h & CMASK) : 16'd0;
			blocks_across <= bd_band.ok ? bd_band.nbx : 15'd0;
			blocks_down   <= bd_band.ok ? bd_band.nby : 15'd0;
			blk_x0        <= blk_ok ? (bx0[15:0] & CMASK) : 16'd0;
			blk_y0        <= blk_ok ? (by0[15:0] & CMASK) : 16'd0;
			blk_x1        <= blk_ok ? (bx1[15:0] & CMASK) : 16'd0;
			blk_y1        <= blk_ok ? (by1[15:0] & CMASK) : 16'd0;
		end
	end

	assign out_valid = valid_q;

endmodule

FILE: hw/rtl/cgc_div_pipe.sv
module cgc_div_pipe import cgc_pkg::*; #(
	parameter int NB = 16,
	parameter int DB = 16,
	parameter int PW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_vld,
	input  logic [NB-1:0] in_dvd,
	input  logic [DB-1:0] in_dsr,
	input  logic [PW-1:0] in_pay,
	output logic          out_vld,
	output logic [NB-1:0] out_quo,
	output logic [DB-1:0] out_rem,
	output logic [PW-1:0] out_pay
);

	logic          vld_s [NB+1];
	logic [NB-1:0] dvd_s [NB+1];
	logic [NB-1:0] quo_s [NB+1];
	logic [DB-1:0] rem_s [NB+1];
	logic [DB-1:0] dsr_s [NB+1];
	logic [PW-1:0] pay_s [NB+1];

	assign vld_s[0] = in_vld;
	assign dvd_s[0] = in_dvd;
	assign quo_s[0] = '0;
	assign rem_s[0] = '0;
	assign dsr_s[0] = in_dsr;
	assign pay_s[0] = in_pay;

	for (genvar k = 0; k < NB; k++) begin : g_stage
		logic [DB:0] trial;
		logic [DB:0] diff;
		logic        ge;

		// one quotient bit per stage, MSB first
		assign trial = {rem_s[k], dvd_s[k][NB-1]};
		assign diff  = trial - {1'b0, dsr_s[k]};
		assign ge    = !diff[DB];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k+1] <= 1'b0;
			else if (en)
				vld_s[k+1] <= vld_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dvd_s[k+1] <= dvd_s[k] << 1;
				quo_s[k+1] <= {quo_s[k][NB-2:0], ge};
				rem_s[k+1] <= ge ? diff[DB-1:0] : trial[DB-1:0];
				dsr_s[k+1] <= dsr_s[k];
				pay_s[k+1] <= pay_s[k];
			end
		end
	end

	assign out_vld = vld_s[NB];
	assign out_quo = quo_s[NB];
	assign out_rem = rem_s[NB];
	assign out_pay = pay_s[NB];

endmodule

FILE: hw/rtl/cgc_band_calc.sv
module cgc_band_calc import cgc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  cfg_t        cfg,
	input  logic        in_vld,
	input  logic [15:0] tile_q,
	input  logic [16:0] tile_p,
	input  query_t      in_qry,
	output logic        out_vld,
	output band_t       out_band,
	output logic [19:0] out_bi
);

	logic [15:0] tw, th;
	logic [2:0]  ew, eh;

	assign tw = nominal_size(cfg.tile_w_set, cfg.image_w);
	assign th = nominal_size(cfg.tile_h_set, cfg.image_h);
	assign ew = clamp_exp(cfg.bexp_w);
	assign eh = clamp_exp(cfg.bexp_h);

	// stage 1: tile origin
	logic        vld_s1;
	logic [31:0] tx0_s1, ty0_s1;
	query_t      qry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (en)
			vld_s1 <= in_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tx0_s1 <= tile_p[15:0] * tw;
			ty0_s1 <= tile_q * th;
			qry_s1 <= in_qry;
		end
	end

	// stage 2: tile end, range checks, depth
	logic        vld_s2, ok_s2;
	logic [15:0] tx0_s2, tx1_s2, ty0_s2, ty1_s2;
	logic [3:0]  d_s2;
	orient_t     ori_s2;
	logic [19:0] bi_s2;

	logic [32:0] tx1_full, ty1_full;
	logic        tile_ok, lvl_ok;
	logic [3:0]  r;
	logic [1:0]  b;

	always_comb begin
		r = qry_s1.res_level;
		b = qry_s1.band_index;
		tx1_full = {1'b0, tx0_s1} + 33'(tw);
		ty1_full = {1'b0, ty0_s1} + 33'(th);
		if (tx1_full > 33'(cfg.image_w))
			tx1_full = 33'(cfg.image_w);
		if (ty1_full > 33'(cfg.image_h))
			ty1_full = 33'(cfg.image_h);
		tile_ok = (cfg.image_w != 16'd0) && (cfg.image_h != 16'd0)
			&& (ty0_s1 < 32'(cfg.image_h));
		lvl_ok = (r <= cfg.decomp) && ((r == 4'd0) ? (b == 2'd0) : (b != 2'd3));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else if (en)
			vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s2  <= tile_ok && lvl_ok;
			tx0_s2 <= tx0_s1[15:0];
			ty0_s2 <= ty0_s1[15:0];
			tx1_s2 <= tx1_full[15:0];
			ty1_s2 <= ty1_full[15:0];
			d_s2   <= (r == 4'd0) ? cfg.decomp : 4'(cfg.decomp - r + 4'd1);
			ori_s2 <= (r == 4'd0) ? ORI_LL : orient_t'(b + 2'd1);
			bi_s2  <= qry_s1.block_index;
		end
	end

	// stage 3: band edges and LL size
	logic        vld_s3, ok_s3;
	logic [15:0] sx0_s3, sx1_s3, sy0_s3, sy1_s3, llw_s3, llh_s3;
	orient_t     ori_s3;
	logic [19:0] bi_s3;

	logic [16:0] rnd, half, xsub, ysub;
	logic [16:0] ex0, ex1, ey0, ey1, elw, elh;

	always_comb begin
		rnd  = (17'd1 << d_s2) - 17'd1;
		half = (d_s2 == 4'd0) ? 17'd0 : (17'd1 << (d_s2 - 4'd1));
		xsub = ori_s2[0] ? half : 17'd0;
		ysub = ori_s2[1] ? half : 17'd0;
		ex0  = (17'(tx0_s2) + rnd - xsub) >> d_s2;
		ex1  = (17'(tx1_s2) + rnd - xsub) >> d_s2;
		ey0  = (17'(ty0_s2) + rnd - ysub) >> d_s2;
		ey1  = (17'(ty1_s2) + rnd - ysub) >> d_s2;
		elw  = (17'(tx1_s2 - tx0_s2) + rnd) >> d_s2;
		elh  = (17'(ty1_s2 - ty0_s2) + rnd) >> d_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s3 <= 1'b0;
		else if (en)
			vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s3  <= ok_s2;
			sx0_s3 <= ex0[15:0];
			sx1_s3 <= ex1[15:0];
			sy0_s3 <= ey0[15:0];
			sy1_s3 <= ey1[15:0];
			llw_s3 <= elw[15:0];
			llh_s3 <= elh[15:0];
			ori_s3 <= ori_s2;
			bi_s3  <= bi_s2;
		end
	end

	// stage 4: band size, packed origin, block grid
	logic        vld_s4;
	band_t       band_s4;
	logic [19:0] bi_s4;

	logic [15:0] bw, bh;
	logic [16:0] nbx_full, nby_full;

	always_comb begin
		bw = sx1_s3 - sx0_s3;
		bh = sy1_s3 - sy0_s3;
		nbx_full = (17'(bw) + ((17'd1 << ew) - 17'd1)) >> ew;
		nby_full = (17'(bh) + ((17'd1 << eh) - 17'd1)) >> eh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s4 <= 1'b0;
		else if (en)
			vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			band_s4.ok      <= ok_s3;
			band_s4.orient  <= ori_s3;
			band_s4.band_x0 <= sx0_s3 + (ori_s3[0] ? llw_s3 : 16'd0);
			band_s4.band_y0 <= sy0_s3 + (ori_s3[1] ? llh_s3 : 16'd0);
			band_s4.band_w  <= bw;
			band_s4.band_h  <= bh;
			band_s4.nbx     <= nbx_full[14:0];
			band_s4.nby     <= nby_full[14:0];
			bi_s4           <= bi_s3;
		end
	end

	assign out_vld  = vld_s4;
	assign out_band = band_s4;
	assign out_bi   = bi_s4;

endmodule

FILE: hw/rtl/cgc_checker.sv
module cgc_checker import cgc_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        valid_res,
	input logic [14:0] blocks_across,
	input logic [14:0] blocks_down,
	input logic [15:0] blk_x0,
	input logic [15:0] blk_y0,
	input logic [15:0] blk_x1,
	input logic [15:0] blk_y1
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(blk_x0) && $stable(blk_y1))
		else $error("result dropped or changed while stalled");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output stalled");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !valid_res |->
			blk_x0 == 16'd0 && blk_y0 == 16'd0 && blk_x1 == 16'd0 && blk_y1 == 16'd0)
		else $error("invalid result carries a block rectangle");

	a_grid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && valid_res |-> blocks_across != 15'd0 && blocks_down != 15'd0)
		else $error("valid block in empty grid");

endmodule

bind codeblock_geometry_calculator_unit cgc_checker u_cgc_checker (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ready), .out_valid(out_valid),
	.out_ready(out_ready), .valid_res(valid_res), .blocks_across(blocks_across),
	.blocks_down(blocks_down), .blk_x0(blk_x0), .blk_y0(blk_y0),
	.blk_x1(blk_x1), .blk_y1(blk_y1)
);
